FILE: design/tkss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkss_pkg
// Shared types and constants for the top-K score selection unit.
// ----------------------------------------------------------------------------
package tkss_pkg;

   localparam int MAX_KEEP    = 8;
   localparam int MAX_CLASSES = 1024;

   localparam int SCORE_W = 8;
   localparam int INDEX_W = $clog2(MAX_CLASSES);
   localparam int KEEP_W  = 4;
   localparam int KCNT_W  = $clog2(MAX_KEEP + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_KEEP_COUNT    = 2'd0;
   localparam logic [1:0] REG_SCORE_FLOOR   = 2'd1;
   localparam logic [1:0] REG_SIGNED_SCORES = 2'd2;

   localparam logic [KEEP_W-1:0]  KEEP_COUNT_RST    = 4'd1;
   localparam logic [SCORE_W-1:0] SCORE_FLOOR_RST   = 8'd3;
   localparam logic               SIGNED_SCORES_RST = 1'b0;

   // one kept (score, index) pair
   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic [INDEX_W-1:0] index;
   } entry_type;

   // candidate broadcast along the cell row
   typedef struct packed {
      logic               accept;
      logic               insert;
      logic               final_beat;
      logic [SCORE_W-1:0] code;
      logic [INDEX_W-1:0] index;
   } cand_type;

   localparam entry_type ENTRY_EMPTY = '{valid: 1'b0, score: '0, index: '0};

endpackage
`default_nettype wire

FILE: design/tkss_rank_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkss_rank_cell
// One slot of the sorted kept list; compares the candidate with its own pair
// and keeps it, takes the candidate or left pair, or clears on a final beat.
// ----------------------------------------------------------------------------
module tkss_rank_cell
   import tkss_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cand_type  cand,
   input  wire logic      active,
   input  wire entry_type prev_entry,
   input  wire logic      prev_beats,
   output entry_type      cur_entry,
   output logic           beats,
   output entry_type      upd_entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      live;

   assign live = entry_ff.valid && active;

   always_comb begin
      cur_entry       = entry_ff;
      cur_entry.valid = live;
   end

   assign beats = !live || (cand.code > entry_ff.score) ||
                  ((cand.code == entry_ff.score) && (cand.index > entry_ff.index));

   always_comb begin
      upd_entry = cur_entry;
      if (cand.insert && active && beats) begin
         if (prev_beats) begin
            upd_entry = prev_entry;
         end else begin
            upd_entry.valid = 1'b1;
            upd_entry.score = cand.code;
            upd_entry.index = cand.index;
         end
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (cand.accept) begin
         entry_in = cand.final_beat ? ENTRY_EMPTY : upd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= ENTRY_EMPTY;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/tkss_drain_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkss_drain_cell
// One slot of the result shift row; loads a snapshot of the list and moves
// toward the output one slot per delivered beat.
// ----------------------------------------------------------------------------
module tkss_drain_cell
   import tkss_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire logic      shift,
   input  wire entry_type load_entry,
   input  wire entry_type next_entry,
   output entry_type      cur_entry
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = load_entry;
      end else if (shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= ENTRY_EMPTY;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign cur_entry = entry_ff;

endmodule
`default_nettype wire

FILE: design/top_k_score_select_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_score_select_unit
// Streaming top-K selection of 8-bit scores with a floor, ranked output.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/ready     req_score_byte, req_final_score
//   rsp      out  rsp_valid/ready     rsp_best_score, rsp_best_index,
//                                     rsp_found, rsp_last_rank
//   csr      in   psel/penable/pready paddr, pwdata, pwrite, prdata
//
// One score per cycle: each rank cell compares and registers its update.
// A final beat snapshots the list into the drain row, which delivers one
// ranked beat per cycle while rsp_ready is high (1..MAX_KEEP beats) as the
// next vector streams in. A final beat stalls only while the previous
// vector drains. Reset is synchronous and clears the list and the counter.
// ----------------------------------------------------------------------------
module top_k_score_select_unit
   import tkss_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [SCORE_W-1:0]    req_score_byte,
   input  wire logic                  req_final_score,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SCORE_W-1:0]         rsp_best_score,
   output logic [INDEX_W-1:0]         rsp_best_index,
   output logic                       rsp_found,
   output logic                       rsp_last_rank,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // configuration registers
   logic [KEEP_W-1:0]  keep_count_ff;
   logic [SCORE_W-1:0] score_floor_ff;
   logic               signed_scores_ff;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff    <= KEEP_COUNT_RST;
         score_floor_ff   <= SCORE_FLOOR_RST;
         signed_scores_ff <= SIGNED_SCORES_RST;
      end else if (csr_wr) begin
         case (paddr[3:2])
            REG_KEEP_COUNT:    keep_count_ff    <= pwdata[KEEP_W-1:0];
            REG_SCORE_FLOOR:   score_floor_ff   <= pwdata[SCORE_W-1:0];
            REG_SIGNED_SCORES: signed_scores_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_KEEP_COUNT:    prdata = {{(CSR_DATA_W-KEEP_W){1'b0}}, keep_count_ff};
         REG_SCORE_FLOOR:   prdata = {{(CSR_DATA_W-SCORE_W){1'b0}}, score_floor_ff};
         REG_SIGNED_SCORES: prdata = {{(CSR_DATA_W-1){1'b0}}, signed_scores_ff};
         default:           prdata = '0;
      endcase
   end

   // active list length
   logic [KCNT_W-1:0] k_eff;

   always_comb begin
      if (keep_count_ff == '0) begin
         k_eff = KCNT_W'(1);
      end else if (32'(keep_count_ff) > MAX_KEEP) begin
         k_eff = KCNT_W'(MAX_KEEP);
      end else begin
         k_eff = KCNT_W'(keep_count_ff);
      end
   end

   // input side
   logic               req_beat;
   logic [SCORE_W-1:0] code;
   logic [INDEX_W-1:0] pos_ff;
   cand_type           cand;

   assign req_beat = req_valid && req_ready;
   assign code     = req_score_byte ^ {signed_scores_ff, {(SCORE_W-1){1'b0}}};

   always_comb begin
      cand.accept     = req_beat;
      cand.insert     = req_beat && (code >= score_floor_ff);
      cand.final_beat = req_final_score;
      cand.code       = code;
      cand.index      = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (req_beat) begin
         pos_ff <= req_final_score ? '0 : pos_ff + INDEX_W'(1);
      end
   end

   // rank row
   entry_type rank_entry [MAX_KEEP];
   entry_type rank_upd   [MAX_KEEP];
   logic      rank_beats [MAX_KEEP];

   for (genvar j = 0; j < MAX_KEEP; j++) begin : g_rank
      entry_type left_entry;
      logic      left_beats;

      if (j == 0) begin : g_head
         assign left_entry = ENTRY_EMPTY;
         assign left_beats = 1'b0;
      end else begin : g_body
         assign left_entry = rank_entry[j-1];
         assign left_beats = rank_beats[j-1];
      end

      tkss_rank_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cand       (cand),
         .active     (KCNT_W'(j) < k_eff),
         .prev_entry (left_entry),
         .prev_beats (left_beats),
         .cur_entry  (rank_entry[j]),
         .beats      (rank_beats[j]),
         .upd_entry  (rank_upd[j])
      );
   end

   // drain row
   entry_type drain_entry [MAX_KEEP];
   logic      busy_ff;
   logic      pop;
   logic      load;
   logic      out_last;

   assign rsp_valid = busy_ff;
   assign pop       = busy_ff && rsp_ready;
   assign load      = req_beat && req_final_score;
   assign req_ready = !req_final_score || !busy_ff || (rsp_ready && out_last);

   for (genvar j = 0; j < MAX_KEEP; j++) begin : g_drain
      entry_type right_entry;

      if (j == MAX_KEEP - 1) begin : g_tail
         assign right_entry = ENTRY_EMPTY;
      end else begin : g_body
         assign right_entry = drain_entry[j+1];
      end

      tkss_drain_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .shift      (pop),
         .load_entry (rank_upd[j]),
         .next_entry (right_entry),
         .cur_entry  (drain_entry[j])
      );
   end

   if (MAX_KEEP > 1) begin : g_last_multi
      assign out_last = !drain_entry[0].valid || !drain_entry[1].valid;
   end else begin : g_last_single
      assign out_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (pop && out_last) begin
         busy_ff <= 1'b0;
      end
   end

   // head of the drain row is the outgoing beat; an empty head means nothing passed
   assign rsp_found      = drain_entry[0].valid;
   assign rsp_best_score = drain_entry[0].valid ? drain_entry[0].score : '0;
   assign rsp_best_index = drain_entry[0].valid ? drain_entry[0].index : '0;
   assign rsp_last_rank  = out_last;

endmodule
`default_nettype wire
